@@ src/pn2d_pkg.sv @@
// Package for the 2-D improved gradient noise block: constants, permutation table
// and gradient helper. No dependencies.
`timescale 1ns / 1ps
package pn2d_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W = 24;
  localparam int CFG_W = 32;
  localparam int OUT_W = 32;
  localparam int REG_RANGE_LOW = 0;
  localparam int REG_RANGE_HIGH = 1;

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
    8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
    8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
    8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
    8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,
    8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,8'd55,
    8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,
    8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,
    8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,
    8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,
    8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
    8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,
    8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,
    8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
    8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,
    8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
    8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,
    8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
    8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180};

  // gradient dot product, 16 improved-noise cases; dx, dy signed 26 bit
  function automatic logic signed [27:0] slope(input logic [3:0] h,
                                               input logic signed [25:0] dx,
                                               input logic signed [25:0] dy);
    logic signed [27:0] u;
    logic signed [27:0] v;
    u = (h < 4'd8) ? 28'(dx) : 28'(dy);
    v = (h < 4'd4) ? 28'(dy) : ((h == 4'd12 || h == 4'd14) ? 28'(dx) : 28'sd0);
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    slope = u + v;
  endfunction
endpackage

@@ src/pn2d_fade.sv @@
// Three-stage quintic fade curve 6t^5-15t^4+10t^3 on one fraction.
// Depends on pn2d_pkg for the default of FRAC_BITS.
`timescale 1ns / 1ps
module pn2d_fade #(
  parameter int FRAC_BITS = pn2d_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [FRAC_BITS-1:0]   frac,
  output logic [FRAC_BITS:0]     weight
);
  localparam int FW = FRAC_BITS;
  logic [FW-1:0]   f1_r, f1_nxt;
  logic [FW-1:0]   t2_r, t2_nxt;
  logic [FW-1:0]   t3_r, t3_nxt;
  logic [FW+4:0]   p_r, p_nxt;
  logic [2*FW-1:0] sq;
  logic [2*FW-1:0] cu;
  logic [2*FW+4:0] pr;
  logic [FW:0]     w_r, w_nxt;

  always_comb begin
    sq = {{FW{1'b0}}, frac} * {{FW{1'b0}}, frac};
    t2_nxt = sq[2*FW-1:FW];
    f1_nxt = frac;
    cu = {{FW{1'b0}}, t2_r} * {{FW{1'b0}}, f1_r};
    t3_nxt = cu[2*FW-1:FW];
    p_nxt = (FW+5)'(6) * (FW+5)'(t2_r) + ((FW+5)'(10) << FW) - (FW+5)'(15) * (FW+5)'(f1_r);
    pr = (2*FW+5)'(t3_r) * (2*FW+5)'(p_r);
    w_nxt = pr[2*FW:FW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r <= f1_nxt;
      t2_r <= t2_nxt;
      t3_r <= t3_nxt;
      p_r  <= p_nxt;
      w_r  <= w_nxt;
    end
  end
  assign weight = w_r;
endmodule

@@ src/pn2d_lerp.sv @@
// Registered blend a + ((w*(b-a))>>F), one multiply per stage.
// Depends on pn2d_pkg only for the default of FRAC_BITS.
`timescale 1ns / 1ps
module pn2d_lerp #(
  parameter int FRAC_BITS = pn2d_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic [FRAC_BITS:0]  w,
  input  logic signed [27:0]  a,
  input  logic signed [27:0]  b,
  output logic signed [27:0]  y
);
  logic signed [28:0] d;
  logic signed [FRAC_BITS+30:0] m;
  logic signed [27:0] y_r, y_nxt;
  always_comb begin
    d = 29'(b) - 29'(a);
    m = $signed({1'b0, w}) * d;
    y_nxt = a + 28'(m >>> FRAC_BITS);
  end
  always_ff @(posedge clk) begin
    if (en) y_r <= y_nxt;
  end
  assign y = y_r;
endmodule

@@ src/perlin_noise_2d_top.sv @@
// Throughput: one sample per cycle while the output register is not stalled.
// The pipeline advances whenever the output register is empty or being taken.
// Stages: ROM hash with fade, second hash, gradients, x blend, y blend, remap product, add.
// Synchronous active-low reset clears valid bits and restores the range registers.
// Depends on pn2d_pkg, pn2d_fade and pn2d_lerp.
`timescale 1ns / 1ps
module perlin_noise_2d_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // x_coord [23:0], y_coord [47:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // noise_value [31:0]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);
  localparam int FW = pn2d_pkg::FRAC_BITS_DEF;
  localparam int NST = 7;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FW;

  logic signed [31:0] lo_r, hi_r;
  logic [NST-1:0] v_r;
  logic en;
  assign en = !v_r[NST-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= -ONE;
      hi_r <= ONE;
      v_r <= '0;
    end else begin
      if (cfg_we && cfg_index == 1'(pn2d_pkg::REG_RANGE_LOW)) lo_r <= cfg_wdata;
      if (cfg_we && cfg_index == 1'(pn2d_pkg::REG_RANGE_HIGH)) hi_r <= cfg_wdata;
      if (en) v_r <= {v_r[NST-2:0], in_tvalid};
    end
  end

  logic [23:0] x, y;
  assign x = in_tdata[23:0];
  assign y = in_tdata[47:24];

  // stage 1: first hash
  logic [7:0] ha1_r, hb1_r;
  logic [FW-1:0] fx1_r, fy1_r;
  logic [7:0] xi;
  assign xi = x[FW+7:FW];
  always_ff @(posedge clk) begin
    if (en) begin
      ha1_r <= pn2d_pkg::PERM[xi] + y[FW+7:FW];
      hb1_r <= pn2d_pkg::PERM[8'(xi + 8'd1)] + y[FW+7:FW];
      fx1_r <= x[FW-1:0];
      fy1_r <= y[FW-1:0];
    end
  end

  // stage 2: second level
  logic [7:0] q00_r, q10_r, q01_r, q11_r;
  logic [FW-1:0] fx2_r, fy2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      q00_r <= pn2d_pkg::PERM[ha1_r];
      q10_r <= pn2d_pkg::PERM[hb1_r];
      q01_r <= pn2d_pkg::PERM[8'(ha1_r + 8'd1)];
      q11_r <= pn2d_pkg::PERM[8'(hb1_r + 8'd1)];
      fx2_r <= fx1_r;
      fy2_r <= fy1_r;
    end
  end

  // stage 3: gradients
  logic signed [25:0] px, py, pxm, pym;
  assign px = 26'($signed({1'b0, fx2_r}));
  assign py = 26'($signed({1'b0, fy2_r}));
  assign pxm = px - 26'(ONE);
  assign pym = py - 26'(ONE);
  logic signed [27:0] g00_r, g10_r, g01_r, g11_r;
  always_ff @(posedge clk) begin
    if (en) begin
      g00_r <= pn2d_pkg::slope(pn2d_pkg::PERM[q00_r][3:0], px, py);
      g10_r <= pn2d_pkg::slope(pn2d_pkg::PERM[q10_r][3:0], pxm, py);
      g01_r <= pn2d_pkg::slope(pn2d_pkg::PERM[q01_r][3:0], px, pym);
      g11_r <= pn2d_pkg::slope(pn2d_pkg::PERM[q11_r][3:0], pxm, pym);
    end
  end

  // fades: fed from the input fraction, weight ready after stage 3 (3 regs)
  logic [FW:0] wu, wv, wv4_r;
  pn2d_fade #(.FRAC_BITS(FW)) u_fx (.clk, .en, .frac(x[FW-1:0]), .weight(wu));
  pn2d_fade #(.FRAC_BITS(FW)) u_fy (.clk, .en, .frac(y[FW-1:0]), .weight(wv));

  // stage 4: x blends
  logic signed [27:0] bx0, bx1, res;
  pn2d_lerp #(.FRAC_BITS(FW)) u_l0 (.clk, .en, .w(wu), .a(g00_r), .b(g10_r), .y(bx0));
  pn2d_lerp #(.FRAC_BITS(FW)) u_l1 (.clk, .en, .w(wu), .a(g01_r), .b(g11_r), .y(bx1));
  always_ff @(posedge clk) begin
    if (en) wv4_r <= wv;
  end
  // stage 5: y blend
  pn2d_lerp #(.FRAC_BITS(FW)) u_l2 (.clk, .en, .w(wv4_r), .a(bx0), .b(bx1), .y(res));

  // stage 6: remap product
  logic signed [32:0] span;
  logic signed [28:0] rp;
  logic signed [61:0] prod_r;
  logic signed [27:0] res6_r;
  logic ident;
  assign span = 33'(hi_r) - 33'(lo_r);
  assign rp = 29'(res) + 29'(ONE);
  assign ident = (lo_r == 32'sd0) && (hi_r == ONE);
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 62'(rp) * 62'(span);
      res6_r <= res;
    end
  end
  // stage 7: shift and add (or pass through when the range is the identity), saturate
  logic signed [46:0] sum;
  logic signed [31:0] o_r;
  assign sum = ident ? 47'(res6_r) : 47'(prod_r >>> (FW + 1)) + 47'(lo_r);
  always_ff @(posedge clk) begin
    if (en) begin
      if (sum > 47'sd2147483647) o_r <= 32'h7FFFFFFF;
      else if (sum < -47'sd2147483648) o_r <= 32'h80000000;
      else o_r <= 32'(sum);
    end
  end
  assign out_tvalid = v_r[NST-1];
  assign out_tdata = o_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output not held");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("stalled while empty");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0]) else $error("transfer lost");
endmodule

@@ test/tb_perlin_noise_2d_top.sv @@
// Self-checking bench for perlin_noise_2d_top: directed and random sample points,
// range settings and stream back-pressure, checked against an in-bench noise predictor.
// Depends on pn2d_pkg and the perlin_noise_2d_top RTL.
`timescale 1ns / 1ps
module tb_perlin_noise_2d_top;

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 << FB;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // x_coord [23:0], y_coord [47:24]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;  // noise_value [31:0]
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  perlin_noise_2d_top DUT (.*);

  logic [31:0] noise_q[$];
  longint      lo_bound, hi_bound;
  int          n_err, n_sent, n_got, n_cfg;
  longint      cycles = 0;
  bit          calm;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint fade(longint f);
    longint t2, t3, p;
    t2 = (f * f) >> FB;
    t3 = (t2 * f) >> FB;
    p = 6 * t2 + 10 * ONE - 15 * f;
    return (t3 * p) >> FB;
  endfunction

  function automatic longint grad(logic [7:0] hash, longint dx, longint dy);
    logic [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? dx : dy;
    v = (h < 4) ? dy : ((h == 12 || h == 14) ? dx : 0);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint mix(longint w, longint a, longint b);
    return a + floor_shr(w * (b - a), FB);
  endfunction

  function automatic logic [31:0] noise_at(logic [23:0] x, logic [23:0] y);
    logic [7:0] xi, yi, ha, hb;
    longint px, py, wu, wv, g00, g10, g01, g11, r;
    xi = x[23:16];
    yi = y[23:16];
    px = x[15:0];
    py = y[15:0];
    wu = fade(px);
    wv = fade(py);
    ha = pn2d_pkg::PERM[xi] + yi;
    hb = pn2d_pkg::PERM[8'(xi + 1)] + yi;
    g00 = grad(pn2d_pkg::PERM[pn2d_pkg::PERM[ha]], px, py);
    g10 = grad(pn2d_pkg::PERM[pn2d_pkg::PERM[hb]], px - ONE, py);
    g01 = grad(pn2d_pkg::PERM[pn2d_pkg::PERM[8'(ha + 1)]], px, py - ONE);
    g11 = grad(pn2d_pkg::PERM[pn2d_pkg::PERM[8'(hb + 1)]], px - ONE, py - ONE);
    r = mix(wv, mix(wu, g00, g10), mix(wu, g01, g11));
    if (lo_bound != 0 || hi_bound != ONE)
      r = floor_shr((r + ONE) * (hi_bound - lo_bound), FB + 1) + lo_bound;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    n_err++;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_got++;
      if (noise_q.size() == 0) report_mismatch("unexpected transfer", out_tdata, 0);
      else begin
        logic [31:0] w;
        w = noise_q.pop_front();
        if (out_tdata !== w) report_mismatch("noise_value", out_tdata, w);
      end
    end
    if (!rst_n || calm) out_tready <= 1'b1;
    else if (out_tready) out_tready <= ($urandom_range(0, 5) != 0);
    else out_tready <= ($urandom_range(0, 2) == 0);
  end

  task automatic send_point(logic [23:0] x, logic [23:0] y);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {y, x};
    do @(posedge clk); while (!in_tready);
    noise_q.push_back(noise_at(x, y));
    n_sent++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_range(longint lo, longint hi);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= 1'(pn2d_pkg::REG_RANGE_LOW);
    cfg_wdata <= lo[31:0];
    @(posedge clk);
    cfg_index <= 1'(pn2d_pkg::REG_RANGE_HIGH);
    cfg_wdata <= hi[31:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    lo_bound = longint'($signed(lo[31:0]));
    hi_bound = longint'($signed(hi[31:0]));
    n_cfg++;
  endtask

  function automatic logic [23:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 24'($urandom_range(0, 1) ? 24'hFFFFFF : 24'h0);
      1: return {8'($urandom), 16'($urandom_range(0, 1) ? 16'hFFFF : 16'h0)};
      2: return {8'hFF, 16'($urandom)};
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic test_directed_points;
    send_point(24'h0, 24'h0);
    send_point(24'hFFFFFF, 24'hFFFFFF);
    send_point(24'hFFFFFF, 24'h0);
    send_point(24'h0, 24'hFFFFFF);
    send_point(24'h008000, 24'h008000);
    send_point(24'hFF8000, 24'h017FFF);
    send_point(24'h00FFFF, 24'h000001);
    send_point(24'hAAAAAA, 24'h555555);
    send_point(24'h555555, 24'hAAAAAA);
    for (int i = 0; i < 16; i++)
      send_point({8'(i * 17), 16'h4000}, {8'(255 - i * 9), 16'hC000});
  endtask

  task automatic test_random_points(int count);
    repeat (count) send_point(rnd_coord(), rnd_coord());
  endtask

  task automatic test_range_settings;
    set_range(0, ONE);                    // identity pass-through
    test_random_points(100);
    set_range(64'sd2147483647, -64'sd2147483648); // inverted extremes
    test_random_points(100);
    set_range(-64'sd2147483648, 64'sd2147483647);
    test_random_points(100);
    set_range(ONE, -ONE);                 // mirrored output
    test_random_points(100);
    set_range(64'sd2000000000, 64'sd2147483647); // pushes into saturation
    test_random_points(100);
    set_range(longint'($signed($urandom)), longint'($signed($urandom)));
    test_random_points(100);
  endtask

  task automatic test_pause_until_empty;
    test_random_points(20);
    drain();
    test_random_points(20);
  endtask

  initial begin
    rst_n = 0; in_tvalid = 0; in_tdata = 0;
    cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    n_err = 0; n_sent = 0; n_got = 0; n_cfg = 0; calm = 0;
    lo_bound = -ONE; hi_bound = ONE;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_points();
    test_random_points(200);
    test_pause_until_empty();
    test_range_settings();
    set_range(-ONE, ONE);
    calm = 1;
    test_random_points(60);
    drain();
    $display("Covered %0d sample points over %0d range settings, %0d results checked.",
             n_sent, n_cfg, n_got);
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
